[hw/rtl/tfb_pkg.sv]
package tfb_pkg;

  localparam int DISPLAY_SLOTS_DEF = 8;
  localparam int ERROR_SLOTS_DEF   = 8;

  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int VALUE_W = 14;
  localparam int BYTE_W  = 8;
  localparam int DIGIT_W = 4;
  localparam int SUM_W   = 7;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_POWER   = 2'd0;
  localparam mode_t MODE_STATE   = 2'd1;
  localparam mode_t MODE_DISPLAY = 2'd2;
  localparam mode_t MODE_ERROR   = 2'd3;

  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_P    = 8'h50;
  localparam logic [BYTE_W-1:0] CH_S    = 8'h53;
  localparam logic [BYTE_W-1:0] CH_D    = 8'h44;
  localparam logic [BYTE_W-1:0] CH_E    = 8'h45;
  localparam logic [BYTE_W-1:0] CH_C    = 8'h43;
  localparam logic [BYTE_W-1:0] CH_HASH = 8'h23;
  localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;

  localparam logic [VALUE_W-1:0] POWER_MAX = 14'd9999;
  localparam logic [VALUE_W-1:0] STATE_MAX = 14'd99;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [SUM_W-1:0]   SUM_MAX   = 7'd99;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAR,
    ST_KIND,
    ST_DIGIT,
    ST_CHECK,
    ST_SUM_HI,
    ST_SUM_LO,
    ST_END
  } fsm_t;

  typedef logic [1:0] place_t;

  localparam place_t PLACE_THOU = 2'd0;
  localparam place_t PLACE_HUND = 2'd1;
  localparam place_t PLACE_TENS = 2'd2;
  localparam place_t PLACE_ONES = 2'd3;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [VALUE_W-1:0] rest;
  } split_t;

  function automatic logic [VALUE_W-1:0] place_scale(place_t p);
    logic [VALUE_W-1:0] s;
    unique case (p)
      PLACE_THOU: s = 14'd1000;
      PLACE_HUND: s = 14'd100;
      PLACE_TENS: s = 14'd10;
      PLACE_ONES: s = 14'd1;
      default: s = 14'd1;
    endcase
    return s;
  endfunction

  // leading decimal digit at one place, by compare against its nine multiples
  function automatic split_t split_digit(logic [VALUE_W-1:0] rem, place_t p);
    logic [VALUE_W-1:0] scl;
    logic [VALUE_W-1:0] prod;
    split_t r;
    scl = place_scale(p);
    prod = '0;
    r.digit = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= VALUE_W'(k) * scl) begin
        r.digit = DIGIT_W'(k);
        prod = VALUE_W'(k) * scl;
      end
    end
    r.rest = rem - prod;
    return r;
  endfunction

endpackage

[hw/rtl/tfb_digit_store.sv]
module tfb_digit_store #(
  parameter int DEPTH = tfb_pkg::DISPLAY_SLOTS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tfb_pkg::DIGIT_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [tfb_pkg::DIGIT_W-1:0] rd_data
);
  import tfb_pkg::*;

  logic [DIGIT_W-1:0] digits_mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic [DIGIT_W-1:0] rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digits_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= digits_mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

[hw/rtl/telemetry_frame_builder.sv]
// channel | ports                                   | direction
// in      | in_valid in_ready in_mode in_slot in_value | request in
// out     | out_valid out_ready out_frame_byte out_last_byte | frame bytes out
//
// one request at a time; a frame is sent one byte per cycle while out_ready is high, from an output register
// a frame holds 10 bytes for power, 8 for state, slot count plus 6 otherwise
// the sequencer walks the digit store one entry per byte through its registered read port
// synchronous active-low reset; digit store entries read as zero until written
// out_ready low while a byte is held freezes the sequencer and the store read port
module telemetry_frame_builder #(
  parameter int DISPLAY_SLOTS = tfb_pkg::DISPLAY_SLOTS_DEF,
  parameter int ERROR_SLOTS   = tfb_pkg::ERROR_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tfb_pkg::MODE_W-1:0]  in_mode,
  input  logic [tfb_pkg::SLOT_W-1:0]  in_slot,
  input  logic [tfb_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tfb_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic                        out_last_byte
);
  import tfb_pkg::*;

  localparam int DAW = (DISPLAY_SLOTS > 1) ? $clog2(DISPLAY_SLOTS) : 1;
  localparam int EAW = (ERROR_SLOTS > 1) ? $clog2(ERROR_SLOTS) : 1;
  localparam int MAX_SLOTS = (DISPLAY_SLOTS > ERROR_SLOTS) ? DISPLAY_SLOTS : ERROR_SLOTS;
  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  fsm_t               state_r, state_nxt;
  mode_t              kind_r;
  logic [VALUE_W-1:0] rem_r;
  place_t             place_r;
  logic [IW-1:0]      idx_r;
  logic [SUM_W-1:0]   sum_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  out_byte_r, byte_nxt;
  logic               out_last_r, last_nxt;

  logic               in_fire, advance, go;
  logic               slot_kind, digit_last;
  logic [IW-1:0]      last_idx, rd_idx;
  logic [SLOT_W-1:0]  slot_m1;
  logic               slot_ok_d, slot_ok_e;
  logic [DIGIT_W-1:0] wr_digit;
  logic               rd_en;
  logic [DIGIT_W-1:0] disp_rd, err_rd, store_digit, cur_digit;
  logic [VALUE_W-1:0] val_sat;
  logic [SUM_W-1:0]   sum_sat;
  split_t             split;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign advance   = !out_valid_r || out_ready;
  assign go        = advance && (state_r != ST_IDLE);
  assign slot_kind = (kind_r == MODE_DISPLAY) || (kind_r == MODE_ERROR);

  // store update at accept
  assign slot_m1   = in_slot - SLOT_W'(1);
  assign slot_ok_d = (in_mode == MODE_DISPLAY) && (in_slot != '0) &&
                     (in_slot <= SLOT_W'(DISPLAY_SLOTS));
  assign slot_ok_e = (in_mode == MODE_ERROR) && (in_slot != '0) &&
                     (in_slot <= SLOT_W'(ERROR_SLOTS));
  assign wr_digit  = (in_value > VALUE_W'(DIGIT_MAX)) ? DIGIT_MAX : in_value[DIGIT_W-1:0];

  assign last_idx  = (kind_r == MODE_ERROR) ? IW'(ERROR_SLOTS - 1) : IW'(DISPLAY_SLOTS - 1);
  assign rd_idx    = (state_r == ST_KIND) ? '0 : idx_r + IW'(1);
  assign rd_en     = go && slot_kind &&
                     ((state_r == ST_KIND) || ((state_r == ST_DIGIT) && (idx_r != last_idx)));

  tfb_digit_store #(.DEPTH(DISPLAY_SLOTS)) u_disp_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && slot_ok_d),
    .wr_addr (slot_m1[DAW-1:0]),
    .wr_data (wr_digit),
    .rd_en   (rd_en && (kind_r == MODE_DISPLAY)),
    .rd_addr (rd_idx[DAW-1:0]),
    .rd_data (disp_rd)
  );

  tfb_digit_store #(.DEPTH(ERROR_SLOTS)) u_err_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_fire && slot_ok_e),
    .wr_addr (slot_m1[EAW-1:0]),
    .wr_data (wr_digit),
    .rd_en   (rd_en && (kind_r == MODE_ERROR)),
    .rd_addr (rd_idx[EAW-1:0]),
    .rd_data (err_rd)
  );

  assign store_digit = (kind_r == MODE_ERROR) ? err_rd : disp_rd;
  assign split       = split_digit(rem_r, place_r);
  assign cur_digit   = slot_kind ? store_digit : split.digit;
  assign digit_last  = slot_kind ? (idx_r == last_idx) : (place_r == PLACE_ONES);
  assign sum_sat     = (sum_r > SUM_MAX) ? SUM_MAX : sum_r;

  always_comb begin
    if (in_mode == MODE_POWER) begin
      val_sat = (in_value > POWER_MAX) ? POWER_MAX : in_value;
    end else begin
      val_sat = (in_value > STATE_MAX) ? STATE_MAX : in_value;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_fire) state_nxt = ST_STAR;
      ST_STAR:   if (go) state_nxt = ST_KIND;
      ST_KIND:   if (go) state_nxt = ST_DIGIT;
      ST_DIGIT:  if (go && digit_last) state_nxt = ST_CHECK;
      ST_CHECK:  if (go) state_nxt = ST_SUM_HI;
      ST_SUM_HI: if (go) state_nxt = ST_SUM_LO;
      ST_SUM_LO: if (go) state_nxt = ST_END;
      ST_END:    if (go) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    byte_nxt = '0;
    last_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE:   byte_nxt = '0;
      ST_STAR:   byte_nxt = CH_STAR;
      ST_KIND: begin
        unique case (kind_r)
          MODE_POWER:   byte_nxt = CH_P;
          MODE_STATE:   byte_nxt = CH_S;
          MODE_DISPLAY: byte_nxt = CH_D;
          MODE_ERROR:   byte_nxt = CH_E;
          default:      byte_nxt = CH_E;
        endcase
      end
      ST_DIGIT:  byte_nxt = CH_ZERO + BYTE_W'(cur_digit);
      ST_CHECK:  byte_nxt = CH_C;
      ST_SUM_HI: byte_nxt = CH_ZERO + BYTE_W'(split.digit);
      ST_SUM_LO: byte_nxt = CH_ZERO + BYTE_W'(split.digit);
      ST_END: begin
        byte_nxt = CH_HASH;
        last_nxt = 1'b1;
      end
      default:   byte_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
    if (in_fire) begin
      kind_r  <= in_mode;
      rem_r   <= val_sat;
      place_r <= (in_mode == MODE_POWER) ? PLACE_THOU : PLACE_TENS;
      idx_r   <= '0;
      sum_r   <= '0;
    end else if (go) begin
      unique case (state_r)
        ST_DIGIT: begin
          sum_r <= sum_r + SUM_W'(cur_digit);
          if (slot_kind) begin
            idx_r <= idx_r + IW'(1);
          end else begin
            rem_r   <= split.rest;
            place_r <= place_r + 2'd1;
          end
        end
        ST_CHECK: begin
          rem_r   <= VALUE_W'(sum_sat);
          place_r <= PLACE_TENS;
        end
        ST_SUM_HI: begin
          rem_r   <= split.rest;
          place_r <= place_r + 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_is_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_frame_byte == CH_HASH)
    else $error("last byte is not the closing mark");

  a_star_opens: assert property (@(posedge clk) disable iff (!rst_n)
    go && state_r == ST_STAR |=> out_valid && out_frame_byte == CH_STAR && !out_last_byte)
    else $error("frame does not open with star");

  a_sum_two_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM_HI |-> rem_r <= VALUE_W'(SUM_MAX))
    else $error("checksum exceeds two digits");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready && state_r == ST_STAR)
    else $error("request accepted while framing");
`endif

endmodule
